@@ hw/rtl/att_pkg.sv @@
`default_nettype none

package att_pkg;

  localparam int unsigned Entries  = 256;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned SlotW    = 8;
  localparam int unsigned SlotPadW = (IdxW > SlotW) ? IdxW : SlotW;

  localparam int unsigned KindW    = 2;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned SizeW    = 40;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 40;

  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic [KindW-1:0] KIND_HEAP = 2'd0;
  localparam logic [KindW-1:0] KIND_VIRT = 2'd1;
  localparam logic [KindW-1:0] KIND_PAGE = 2'd2;

  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL      = 2'd1;
  localparam logic [StatusW-1:0] STATUS_UNTRACKED = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_HEAP_MIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_HEAP_MAX  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_VIRT_MIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_VIRT_MAX  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_MIN  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PAGE_MAX  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_RANGE_EN  = 3'd6;

  localparam logic [SizeW-1:0] HEAP_MIN_RST = 40'd9;
  localparam logic [SizeW-1:0] HEAP_MAX_RST = 40'd16383;
  localparam logic [SizeW-1:0] VIRT_MIN_RST = 40'd9;
  localparam logic [SizeW-1:0] VIRT_MAX_RST = 40'd1048575;
  localparam logic [SizeW-1:0] PAGE_MIN_RST = 40'd4095;
  localparam logic [SizeW-1:0] PAGE_MAX_RST = 40'd32767;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [AddrW-1:0] addr;
    logic [SizeW-1:0] size;
  } att_entry_t;

  typedef struct packed {
    logic            load;
    logic            issue;
    logic [IdxW-1:0] idx;
    logic            commit;
  } att_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_vld;
  } att_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/att_in_if.sv @@
`default_nettype none

interface att_in_if ();
  logic                               valid;
  logic                               ready;
  logic                               req_type;
  logic [att_pkg::KindW-1:0]          mem_kind;
  logic [att_pkg::AddrW-1:0]          block_addr;
  logic [att_pkg::SizeW-1:0]          block_size;

  modport source (output valid, output req_type, output mem_kind, output block_addr,
                  output block_size, input ready);
  modport sink   (input valid, input req_type, input mem_kind, input block_addr,
                  input block_size, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/att_out_if.sv @@
`default_nettype none

interface att_out_if ();
  logic                               valid;
  logic                               ready;
  logic [att_pkg::StatusW-1:0]        status;
  logic [att_pkg::SlotW-1:0]          slot;
  logic                               size_out_of_range;
  logic [att_pkg::CountW-1:0]         overlap_count;
  logic                               size_mismatch;

  modport source (output valid, output status, output slot, output size_out_of_range,
                  output overlap_count, output size_mismatch, input ready);
  modport sink   (input valid, input status, input slot, input size_out_of_range,
                  input overlap_count, input size_mismatch, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/att_ctrl.sv @@
`default_nettype none

module att_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_ready_o,
  input  wire                  out_ready_i,
  input  wire att_pkg::att_sts_t sts_i,
  output att_pkg::att_cmd_t    cmd_o
);

  localparam int unsigned IdxW = att_pkg::IdxW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(att_pkg::Entries - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_COMMIT = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            can_commit;

  assign can_commit = !sts_i.out_vld || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cmd_o        = '0;
    cmd_o.idx    = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        if (idx_q == LastIdx) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // wait for the last entries to leave the compare pipeline
        if (!sts_i.busy) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (can_commit) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  a_commit_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> !sts_i.busy)
    else $error("commit while compare pipeline busy");

  a_issue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |=> sts_i.busy)
    else $error("issued read did not enter the pipeline");

  a_commit_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!sts_i.out_vld || out_ready_i))
    else $error("commit would overwrite a pending result");

endmodule

`default_nettype wire

@@ hw/rtl/att_datapath.sv @@
`default_nettype none

module att_datapath (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire att_pkg::att_cmd_t          cmd_i,
  output att_pkg::att_sts_t               sts_o,
  input  wire                             req_type_i,
  input  wire [att_pkg::KindW-1:0]        mem_kind_i,
  input  wire [att_pkg::AddrW-1:0]        block_addr_i,
  input  wire [att_pkg::SizeW-1:0]        block_size_i,
  input  wire                             cfg_we_i,
  input  wire [att_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [att_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  wire                             out_ready_i,
  output logic [att_pkg::StatusW-1:0]     status_o,
  output logic [att_pkg::SlotW-1:0]       slot_o,
  output logic                            size_out_of_range_o,
  output logic [att_pkg::CountW-1:0]      overlap_count_o,
  output logic                            size_mismatch_o
);

  localparam int unsigned Entries = att_pkg::Entries;
  localparam int unsigned IdxW    = att_pkg::IdxW;
  localparam int unsigned PadW    = att_pkg::SlotPadW;
  localparam int unsigned AddrW   = att_pkg::AddrW;
  localparam int unsigned SizeW   = att_pkg::SizeW;
  localparam int unsigned WideW   = AddrW + 1;

  // configuration
  logic [SizeW-1:0] heap_min_q, heap_max_q, virt_min_q, virt_max_q, page_min_q, page_max_q;
  logic             range_en_q;

  // request
  logic                req_free_q;
  att_pkg::att_entry_t req_q;
  logic [WideW-1:0]    m_sum_q, m_last_q;

  // table
  logic [Entries-1:0]  valid_q;
  att_pkg::att_entry_t mem [Entries];

  // scan pipeline
  logic                p1_vld_q, p1_ent_q;
  logic [IdxW-1:0]     p1_idx_q;
  att_pkg::att_entry_t rd_q;
  logic                p2_vld_q, p2_same_q, p2_ma_ge_q, p2_ml_ge_q;
  logic [WideW-1:0]    p2_end_q;

  logic                found_q;
  logic [IdxW-1:0]     found_idx_q;
  logic [SizeW-1:0]    found_size_q;
  logic [att_pkg::CountW-1:0] count_q;

  logic out_vld_q;

  logic             hit, ma_lt_end, ml_lt_end, ovl;
  logic             oor_c, chk_c;
  logic [SizeW-1:0] lo_c, hi_c;
  logic [PadW-1:0]  slot_pad;

  assign sts_o.busy    = p1_vld_q || p2_vld_q;
  assign sts_o.out_vld = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_min_q <= att_pkg::HEAP_MIN_RST;
      heap_max_q <= att_pkg::HEAP_MAX_RST;
      virt_min_q <= att_pkg::VIRT_MIN_RST;
      virt_max_q <= att_pkg::VIRT_MAX_RST;
      page_min_q <= att_pkg::PAGE_MIN_RST;
      page_max_q <= att_pkg::PAGE_MAX_RST;
      range_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        att_pkg::CFG_HEAP_MIN: heap_min_q <= cfg_wdata_i;
        att_pkg::CFG_HEAP_MAX: heap_max_q <= cfg_wdata_i;
        att_pkg::CFG_VIRT_MIN: virt_min_q <= cfg_wdata_i;
        att_pkg::CFG_VIRT_MAX: virt_max_q <= cfg_wdata_i;
        att_pkg::CFG_PAGE_MIN: page_min_q <= cfg_wdata_i;
        att_pkg::CFG_PAGE_MAX: page_max_q <= cfg_wdata_i;
        att_pkg::CFG_RANGE_EN: range_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // request latch; last byte of the new block is registered in the cycle after the sum
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_free_q   <= req_type_i;
      req_q.kind   <= mem_kind_i;
      req_q.addr   <= block_addr_i;
      req_q.size   <= block_size_i;
      m_sum_q      <= {1'b0, block_addr_i} + WideW'(block_size_i);
    end
    m_last_q <= m_sum_q - WideW'(1);
  end

  // table storage, one read or one write per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && found_q && !req_free_q) begin
      mem[found_idx_q] <= req_q;
    end
    if (cmd_i.issue) begin
      rd_q <= mem[cmd_i.idx];
    end
    p1_idx_q <= cmd_i.idx;
    p1_ent_q <= valid_q[cmd_i.idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      p1_vld_q  <= 1'b0;
      p2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= cmd_i.issue;
      p2_vld_q <= p1_vld_q;
      if (cmd_i.commit && found_q) begin
        valid_q[found_idx_q] <= !req_free_q;
      end
      if (cmd_i.commit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // first-hit search: lowest free entry on alloc, lowest matching entry on free
  assign hit = req_free_q ? (p1_ent_q && rd_q.kind == req_q.kind && rd_q.addr == req_q.addr)
                          : !p1_ent_q;

  assign ma_lt_end = {1'b0, req_q.addr} < p2_end_q;
  assign ml_lt_end = m_last_q < p2_end_q;
  assign ovl = (p2_ma_ge_q && ma_lt_end) || (p2_ml_ge_q && ml_lt_end) ||
               (!p2_ma_ge_q && !ml_lt_end);

  always_ff @(posedge clk_i) begin
    p2_same_q  <= p1_ent_q && (rd_q.kind == req_q.kind);
    p2_end_q   <= {1'b0, rd_q.addr} + WideW'(rd_q.size);
    p2_ma_ge_q <= req_q.addr >= rd_q.addr;
    p2_ml_ge_q <= m_last_q >= {1'b0, rd_q.addr};
    if (cmd_i.load) begin
      found_q <= 1'b0;
      count_q <= '0;
    end else begin
      if (p1_vld_q && hit && !found_q) begin
        found_q      <= 1'b1;
        found_idx_q  <= p1_idx_q;
        found_size_q <= rd_q.size;
      end
      if (p2_vld_q && p2_same_q && ovl && count_q != att_pkg::CountMax) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_comb begin
    lo_c  = heap_min_q;
    hi_c  = heap_max_q;
    chk_c = 1'b1;
    case (req_q.kind)
      att_pkg::KIND_HEAP: begin
        lo_c = heap_min_q;
        hi_c = heap_max_q;
      end
      att_pkg::KIND_VIRT: begin
        lo_c = virt_min_q;
        hi_c = virt_max_q;
      end
      att_pkg::KIND_PAGE: begin
        lo_c = page_min_q;
        hi_c = page_max_q;
      end
      default: begin
        chk_c = 1'b0;
      end
    endcase
    oor_c = range_en_q && chk_c && (req_q.size < lo_c || req_q.size > hi_c);
  end

  assign slot_pad = PadW'(found_idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      if (found_q) begin
        status_o            <= att_pkg::STATUS_OK;
        slot_o              <= slot_pad[att_pkg::SlotW-1:0];
        size_out_of_range_o <= !req_free_q && oor_c;
        overlap_count_o     <= req_free_q ? '0 : count_q;
        size_mismatch_o     <= req_free_q && req_q.kind == att_pkg::KIND_PAGE &&
                               req_q.size != found_size_q;
      end else begin
        status_o            <= req_free_q ? att_pkg::STATUS_UNTRACKED : att_pkg::STATUS_FULL;
        slot_o              <= '0;
        size_out_of_range_o <= 1'b0;
        overlap_count_o     <= '0;
        size_mismatch_o     <= 1'b0;
      end
    end
  end

  a_alloc_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && found_q && !req_free_q |=> valid_q[$past(found_idx_q)])
    else $error("allocated entry not marked in use");

  a_free_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && found_q && req_free_q |=> !valid_q[$past(found_idx_q)])
    else $error("freed entry still marked in use");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && !found_q |=> slot_o == '0 && overlap_count_o == '0 &&
                                 status_o != att_pkg::STATUS_OK)
    else $error("failed request reports nonzero fields");

endmodule

`default_nettype wire

@@ hw/rtl/allocation_tracking_table.sv @@
// Flow: an accepted request scans the whole table, one table read per cycle; then the
// compare pipeline drains and the result is committed once the output is free or its
// pending result is being accepted (out_ready back-pressure can hold the commit).
// A new request is taken only after the last one has committed, set by the single-port table scan.
// Reset (rst_ni, async, active low) marks every entry unused and restores register defaults.
`default_nettype none

module allocation_tracking_table (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  att_in_if.sink                       in_if,
  att_out_if.source                    out_if,
  input  wire                          cfg_we_i,
  input  wire [att_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire [att_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  att_pkg::att_cmd_t cmd;
  att_pkg::att_sts_t sts;
  logic              in_ready;

  assign in_if.ready  = in_ready;
  assign out_if.valid = sts.out_vld;

  att_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_ready),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  att_datapath u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .req_type_i          (in_if.req_type),
    .mem_kind_i          (in_if.mem_kind),
    .block_addr_i        (in_if.block_addr),
    .block_size_i        (in_if.block_size),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .out_ready_i         (out_if.ready),
    .status_o            (out_if.status),
    .slot_o              (out_if.slot),
    .size_out_of_range_o (out_if.size_out_of_range),
    .overlap_count_o     (out_if.overlap_count),
    .size_mismatch_o     (out_if.size_mismatch)
  );

endmodule

`default_nettype wire
